// ===== hdl/mlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpq_pkg: shared types and constants
// Codes, field widths and defaults for the multi-level priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpq_pkg;

  // defaults for the top-level parameters
  localparam int LEVELS_DEF    = 8;
  localparam int DEPTH_DEF     = 16;
  localparam int DATA_BITS_DEF = 32;

  // fixed field widths
  localparam int ELEM_W         = 32;
  localparam int PRIO_W         = 8;
  localparam int LEVEL_OUT_W    = 3;
  localparam int CFG_LEVELS_W   = 4;
  localparam int CFG_CAPACITY_W = 5;
  localparam int CFG_DATA_W     = 5;
  localparam int CFG_IDX_W      = 1;

  // register reset values
  localparam logic [CFG_LEVELS_W-1:0]   LEVELS_RST   = 4'd8;
  localparam logic [CFG_CAPACITY_W-1:0] CAPACITY_RST = 5'd16;

  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic [PRIO_W-1:0]         prio_t;
  typedef logic [LEVEL_OUT_W-1:0]    level_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVELS   = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_PTR  = 2'd1,
    S_DATA = 2'd2,
    S_DONE = 2'd3
  } state_e;

endpackage

`default_nettype wire

// ===== hdl/mlpq_if.sv =====
// ----------------------------------------------------------------------------
// mlpq_if: request and response channels
// Valid/ready channels carrying one queue operation and one queue result.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlpq_in_if;
  import mlpq_pkg::*;

  logic  valid;
  logic  ready;
  op_e   operation;
  elem_t element;
  prio_t priority_req;

  modport source (output valid, output operation, output element, output priority_req,
                  input ready);
  modport sink   (input valid, input operation, input element, input priority_req,
                  output ready);
endinterface

interface mlpq_out_if;
  import mlpq_pkg::*;

  logic       valid;
  logic       ready;
  status_e    status;
  elem_t      element_out;
  level_out_t level_out;

  modport source (output valid, output status, output element_out, output level_out,
                  input ready);
  modport sink   (input valid, input status, input element_out, input level_out,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/multi_level_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// multi_level_priority_queue_core: FIFO per priority level
// Enqueue appends to one level's circular FIFO; dequeue pops the oldest
// element of the lowest-numbered non-empty level in use.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  -----------------------------------------------
//  in_chan   in   operation, element, priority_req
//  out_chan  out  status, element_out, level_out (one per input beat)
//  cfg_*     in   cfg_we_i, cfg_idx_i, cfg_wdata_i (no handshake)
//
//  Flow: one item at a time. Invalid priority / all-empty go from S_IDLE
//  straight to S_DONE; enqueue passes S_PTR, the read-modify-write of the
//  pointer memory; dequeue adds S_DATA, the registered entry-memory read.
//  Reset: asynchronous, clears control, config to levels=8, capacity=16,
//  and every level to empty; no clearing pass, ready right after reset.
//  Stalls: the result sits in an output register; the next beat is taken
//  while it waits, and the core holds in S_DONE only if a second result
//  is ready before the first one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_level_priority_queue_core #(
  parameter int LEVELS    = mlpq_pkg::LEVELS_DEF,
  parameter int DEPTH     = mlpq_pkg::DEPTH_DEF,
  parameter int DATA_BITS = mlpq_pkg::DATA_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  mlpq_in_if.sink                              in_chan,
  mlpq_out_if.source                           out_chan,
  input  wire logic                            cfg_we_i,
  input  wire logic [mlpq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mlpq_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import mlpq_pkg::*;

  localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int PW      = 2 * SW + CW;
  localparam int ENTRIES = LEVELS * DEPTH;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int XW      = (CW > CFG_CAPACITY_W) ? CW : CFG_CAPACITY_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_LEVELS_W-1:0]   lvl_cfg_q;
  logic [CFG_CAPACITY_W-1:0] cap_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_cfg_q <= LEVELS_RST;
      cap_cfg_q <= CAPACITY_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_LEVELS) begin
        lvl_cfg_q <= cfg_wdata_i[CFG_LEVELS_W-1:0];
      end
      if (cfg_idx_i == CFG_CAPACITY) begin
        cap_cfg_q <= cfg_wdata_i[CFG_CAPACITY_W-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  op_e               op_q;
  elem_t             elem_q;
  logic [LW-1:0]     lvl_q;
  status_e           res_status_q, res_status_d;
  elem_t             res_elem_q, res_elem_d;
  level_out_t        res_lvl_q, res_lvl_d;
  logic [LEVELS-1:0] nonempty_q, nonempty_d;

  logic              out_valid_q;
  status_e           out_status_q;
  elem_t             out_elem_q;
  level_out_t        out_lvl_q;

  logic              in_ready;
  logic              in_acc;
  logic              out_free;
  logic              load_out;

  // memory ports
  logic [LW-1:0]        ptr_raddr;
  logic [PW-1:0]        ptr_rdata;
  logic                 ptr_we;
  logic [PW-1:0]        ptr_wdata;
  logic                 ent_we;
  logic [AW-1:0]        ent_waddr;
  logic [DATA_BITS-1:0] ent_wdata;
  logic                 ent_re;
  logic [AW-1:0]        ent_raddr;
  logic [DATA_BITS-1:0] ent_rdata;

  // --------------------------------------------------------------------------
  // level selection: enqueue validity and dequeue priority encode
  // --------------------------------------------------------------------------
  logic [LEVELS-1:0] lvl_mask;
  logic [LEVELS-1:0] cand;
  logic              deq_hit;
  logic [LW-1:0]     deq_lvl;
  logic              prio_ok;
  logic [LW-1:0]     req_lvl;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      lvl_mask[i] = (i < int'(lvl_cfg_q));
    end
  end

  assign cand    = nonempty_q & lvl_mask;
  assign deq_hit = |cand;

  always_comb begin
    deq_lvl = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        deq_lvl = LW'(i);
      end
    end
  end

  // level count register above LEVELS acts as LEVELS
  assign prio_ok = (in_chan.priority_req < {4'b0, lvl_cfg_q}) &&
                   ({1'b0, in_chan.priority_req} < 9'(LEVELS));
  assign req_lvl = (in_chan.operation == OP_ENQ) ? in_chan.priority_req[LW-1:0] : deq_lvl;

  // --------------------------------------------------------------------------
  // pointer record fields
  // --------------------------------------------------------------------------
  logic [SW-1:0] head, tail;
  logic [CW-1:0] cnt;
  logic          full;
  logic [AW-1:0] lvl_base;

  assign head = ptr_rdata[PW-1 -: SW];
  assign tail = ptr_rdata[CW+SW-1 -: SW];
  assign cnt  = ptr_rdata[CW-1:0];

  // capacity register above DEPTH acts as DEPTH
  assign full     = (XW'(cnt) >= XW'(cap_cfg_q)) || (cnt == CW'(DEPTH));
  assign lvl_base = AW'(lvl_q) * AW'(DEPTH);

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    next_slot = (int'(s) + 1 >= DEPTH) ? '0 : s + SW'(1);
  endfunction

  assign in_ready = (state_q == S_IDLE);
  assign in_acc   = in_chan.valid && in_ready;
  assign out_free = !out_valid_q || out_chan.ready;

  // --------------------------------------------------------------------------
  // next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if ((in_chan.operation == OP_ENQ && !prio_ok) ||
              (in_chan.operation == OP_DEQ && !deq_hit)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PTR;
          end
        end
      end
      S_PTR: begin
        state_d = (op_q == OP_DEQ) ? S_DATA : S_DONE;
      end
      S_DATA: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    ptr_raddr    = req_lvl;
    ptr_we       = 1'b0;
    ptr_wdata    = ptr_rdata;
    ent_we       = 1'b0;
    ent_waddr    = lvl_base + AW'(tail);
    ent_wdata    = DATA_BITS'(elem_q);
    ent_re       = 1'b0;
    ent_raddr    = lvl_base + AW'(head);
    nonempty_d   = nonempty_q;
    res_status_d = res_status_q;
    res_elem_d   = res_elem_q;
    res_lvl_d    = res_lvl_q;
    load_out     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_elem_d   = '0;
          res_lvl_d    = '0;
          res_status_d = ST_OK;
          if (in_chan.operation == OP_ENQ) begin
            if (!prio_ok) begin
              res_status_d = ST_INVALID;
            end
          end else if (!deq_hit) begin
            res_status_d = ST_EMPTY;
          end else begin
            res_lvl_d = level_out_t'(deq_lvl);
          end
        end
      end
      S_PTR: begin
        if (op_q == OP_ENQ) begin
          if (full) begin
            res_status_d = ST_FULL;
          end else begin
            ent_we             = 1'b1;
            ptr_we             = 1'b1;
            ptr_wdata          = {head, next_slot(tail), cnt + CW'(1)};
            nonempty_d[lvl_q]  = 1'b1;
          end
        end else begin
          ent_re            = 1'b1;
          ptr_we            = 1'b1;
          ptr_wdata         = {next_slot(head), tail, cnt - CW'(1)};
          nonempty_d[lvl_q] = (cnt != CW'(1));
        end
      end
      S_DATA: begin
        // stored word is sign-extended from DATA_BITS
        res_elem_d = ELEM_W'(signed'(ent_rdata));
      end
      S_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      nonempty_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      nonempty_q <= nonempty_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= in_chan.operation;
      elem_q <= in_chan.element;
      lvl_q  <= req_lvl;
    end
    res_status_q <= res_status_d;
    res_elem_q   <= res_elem_d;
    res_lvl_q    <= res_lvl_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_elem_q   <= res_elem_q;
      out_lvl_q    <= res_lvl_q;
    end
  end

  assign in_chan.ready        = in_ready;
  assign out_chan.valid       = out_valid_q;
  assign out_chan.status      = out_status_q;
  assign out_chan.element_out = out_elem_q;
  assign out_chan.level_out   = out_lvl_q;

  // --------------------------------------------------------------------------
  // memories
  // --------------------------------------------------------------------------
  mlpq_ptr_store #(
    .LEVELS (LEVELS),
    .LW     (LW),
    .PW     (PW)
  ) u_ptr_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (ptr_raddr),
    .rd_data_o (ptr_rdata),
    .we_i      (ptr_we),
    .wr_addr_i (lvl_q),
    .wr_data_i (ptr_wdata)
  );

  mlpq_entry_store #(
    .ENTRIES   (ENTRIES),
    .AW        (AW),
    .DATA_BITS (DATA_BITS)
  ) u_entry_store (
    .clk_i     (clk_i),
    .we_i      (ent_we),
    .wr_addr_i (ent_waddr),
    .wr_data_i (ent_wdata),
    .re_i      (ent_re),
    .rd_addr_i (ent_raddr),
    .rd_data_o (ent_rdata)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_ent_we_enq_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |-> (state_q == S_PTR && op_q == OP_ENQ))
    else $error("entry write outside enqueue update");

  a_accept_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_PTR || state_q == S_DONE))
    else $error("accepted beat not processed");

  a_flags_only_in_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_PTR) |=> $stable(nonempty_q))
    else $error("level flags changed outside pointer update");

  a_deq_data_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DATA) |-> (res_status_q == ST_OK))
    else $error("dequeue read without a hit");

  a_done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free) |=> out_valid_q)
    else $error("result not moved to output register");

endmodule

`default_nettype wire

// ===== hdl/mlpq_ptr_store.sv =====
// ----------------------------------------------------------------------------
// mlpq_ptr_store: per-level head, tail and fill record
// One-port-read, one-port-write memory; a record never written reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpq_ptr_store #(
  parameter int LEVELS = mlpq_pkg::LEVELS_DEF,
  parameter int LW     = 3,
  parameter int PW     = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [LW-1:0] rd_addr_i,
  output logic      [PW-1:0] rd_data_o,
  input  wire logic          we_i,
  input  wire logic [LW-1:0] wr_addr_i,
  input  wire logic [PW-1:0] wr_data_i
);
  import mlpq_pkg::*;

  logic [PW-1:0]     mem [LEVELS];
  logic [LEVELS-1:0] vld_q;
  logic [PW-1:0]     rd_q;
  logic              rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  // written-once flags stand in for the all-zero reset of the record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// ===== hdl/mlpq_entry_store.sv =====
// ----------------------------------------------------------------------------
// mlpq_entry_store: element storage
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpq_entry_store #(
  parameter int ENTRIES   = 128,
  parameter int AW        = 7,
  parameter int DATA_BITS = mlpq_pkg::DATA_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 we_i,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire logic [DATA_BITS-1:0] wr_data_i,
  input  wire logic                 re_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output logic      [DATA_BITS-1:0] rd_data_o
);
  import mlpq_pkg::*;

  logic [DATA_BITS-1:0] mem [ENTRIES];
  logic [DATA_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (re_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire
